// File: sv/ilp_pkg.sv
// Shared types and constants for the integer literal parser.
// No dependencies; compiled first.
package ilp_pkg;

	localparam int VALUE_W   = 64;
	localparam int CHAR_W    = 8;
	localparam int NUM_TYPES = 6;
	localparam int CFG_IDX_W = 3;
	localparam int TYPE_W    = 3;
	localparam int STATUS_W  = 2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	localparam logic [TYPE_W-1:0] TY_INT   = 3'd0;
	localparam logic [TYPE_W-1:0] TY_LONG  = 3'd2;
	localparam logic [TYPE_W-1:0] TY_LLONG = 3'd4;

	localparam logic [VALUE_W-1:0] RST_MAX [NUM_TYPES] = '{
		64'd2147483647,
		64'd4294967295,
		64'd9223372036854775807,
		64'hFFFF_FFFF_FFFF_FFFF,
		64'd9223372036854775807,
		64'hFFFF_FFFF_FFFF_FFFF
	};

	// character class from the front end
	typedef struct packed {
		logic       is_final;
		logic       is_dec;
		logic       is_oct;
		logic       is_hex;
		logic       is_zero;
		logic       is_x;
		logic       is_l;
		logic       is_u;
		logic [3:0] digit;
	} char_class_t;

	// finished literal, before type selection
	typedef struct packed {
		logic               bad;
		logic               is_decimal;
		logic               single_l;
		logic               double_l;
		logic               seen_u;
		logic [VALUE_W-1:0] value;
	} lit_rec_t;

endpackage

// File: sv/ilp_if.sv
// Channel interfaces: character input and literal result output.
// Depends on ilp_pkg.
interface ilp_in_if;
	import ilp_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              is_final;
	modport source(output valid, char_code, is_final, input ready);
	modport sink(input valid, char_code, is_final, output ready);
endinterface

interface ilp_out_if;
	import ilp_pkg::*;
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  literal_value;
	logic [TYPE_W-1:0]   type_code;
	logic [STATUS_W-1:0] status;
	modport source(output valid, literal_value, type_code, status, input ready);
	modport sink(input valid, literal_value, type_code, status, output ready);
endinterface

// File: sv/ilp_front.sv
// Front end: classifies each input character and queues it (two entries).
// Depends on ilp_pkg and ilp_in_if.
module ilp_front (
	input  logic                clk,
	input  logic                arst_n,
	ilp_in_if.sink              char_in,
	output logic                cls_valid,
	input  logic                cls_ready,
	output ilp_pkg::char_class_t cls
);
	import ilp_pkg::*;

	char_class_t    mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	char_class_t    cls_in;
	logic [CHAR_W-1:0] c;
	logic           push;
	logic           pop;

	assign c = char_in.char_code;

	always_comb begin
		cls_in          = '0;
		cls_in.is_final = char_in.is_final;
		cls_in.is_dec   = (c >= 8'h30) && (c <= 8'h39);
		cls_in.is_oct   = (c >= 8'h30) && (c <= 8'h37);
		cls_in.is_zero  = (c == 8'h30);
		cls_in.is_x     = (c == 8'h78) || (c == 8'h58);
		cls_in.is_l     = (c == 8'h6C) || (c == 8'h4C);
		cls_in.is_u     = (c == 8'h75) || (c == 8'h55);
		cls_in.is_hex   = cls_in.is_dec || ((c >= 8'h61) && (c <= 8'h66))
			|| ((c >= 8'h41) && (c <= 8'h46));
		if (cls_in.is_dec)
			cls_in.digit = c[3:0];
		else
			cls_in.digit = {1'b0, c[2:0]} + 4'd9;
	end

	assign char_in.ready = (count_q != 2'd2);
	assign push          = char_in.valid && char_in.ready;
	assign cls_valid     = (count_q != 2'd0);
	assign pop           = cls_valid && cls_ready;
	assign cls           = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= cls_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: sv/ilp_back.sv
// Back end: literal state machine and accumulator; emits a record per literal.
// Depends on ilp_pkg.
module ilp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cls_valid,
	output logic                 cls_ready,
	input  ilp_pkg::char_class_t cls,
	output logic                 rec_valid,
	input  logic                 rec_ready,
	output ilp_pkg::lit_rec_t    rec
);
	import ilp_pkg::*;

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_ZERO   = 3'd1;
	localparam logic [2:0] PH_OCT    = 3'd2;
	localparam logic [2:0] PH_HEX    = 3'd3;
	localparam logic [2:0] PH_DEC    = 3'd4;
	localparam logic [2:0] PH_SUFFIX = 3'd5;

	logic [2:0]         phase_q, phase_d;
	logic [VALUE_W-1:0] acc_q, acc_d;
	logic               dec_q, dec_d;
	logic               sl_q, sl_d;
	logic               dl_q, dl_d;
	logic               u_q, u_d;
	logic               bad_q, bad_d;
	logic               rec_valid_s1;
	lit_rec_t           rec_s1;
	logic               rec_free;
	logic               take;
	logic [VALUE_W-1:0] acc_x8, acc_x10, acc_x16;

	assign acc_x8  = acc_q << 3;
	assign acc_x16 = acc_q << 4;
	assign acc_x10 = acc_x8 + (acc_q << 1);

	assign rec_free  = !rec_valid_s1 || rec_ready;
	assign cls_ready = !cls.is_final || rec_free;
	assign take      = cls_valid && cls_ready;
	assign rec_valid = rec_valid_s1;
	assign rec       = rec_s1;

	always_comb begin
		logic do_suffix;
		do_suffix = 1'b0;
		phase_d   = phase_q;
		acc_d     = acc_q;
		dec_d     = dec_q;
		sl_d      = sl_q;
		dl_d      = dl_q;
		u_d       = u_q;
		bad_d     = bad_q;
		if (!bad_q) begin
			unique case (phase_q)
				PH_START: begin
					if (cls.is_zero) begin
						dec_d   = 1'b0;
						phase_d = PH_ZERO;
					end else if (cls.is_dec) begin
						phase_d = PH_DEC;
						acc_d   = acc_x10 + VALUE_W'(cls.digit);
					end else begin
						do_suffix = 1'b1;
					end
				end
				PH_ZERO: begin
					if (cls.is_x) begin
						phase_d = PH_HEX;
					end else if (cls.is_oct) begin
						phase_d = PH_OCT;
						acc_d   = acc_x8 + VALUE_W'(cls.digit);
					end else begin
						do_suffix = 1'b1;
					end
				end
				PH_OCT: begin
					if (cls.is_oct)
						acc_d = acc_x8 + VALUE_W'(cls.digit);
					else
						do_suffix = 1'b1;
				end
				PH_HEX: begin
					if (cls.is_hex)
						acc_d = acc_x16 + VALUE_W'(cls.digit);
					else
						do_suffix = 1'b1;
				end
				PH_DEC: begin
					if (cls.is_dec)
						acc_d = acc_x10 + VALUE_W'(cls.digit);
					else
						do_suffix = 1'b1;
				end
				default: do_suffix = 1'b1;
			endcase
		end
		if (do_suffix) begin
			phase_d = PH_SUFFIX;
			priority if (cls.is_l) begin
				priority if (sl_q) begin
					sl_d = 1'b0;
					dl_d = 1'b1;
				end else if (dl_q) begin
					bad_d = 1'b1;
				end else begin
					sl_d = 1'b1;
				end
			end else if (cls.is_u) begin
				if (u_q)
					bad_d = 1'b1;
				u_d = 1'b1;
			end else begin
				bad_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && cls.is_final) begin
			rec_s1.bad        <= bad_d;
			rec_s1.is_decimal <= dec_d;
			rec_s1.single_l   <= sl_d;
			rec_s1.double_l   <= dl_d;
			rec_s1.seen_u     <= u_d;
			rec_s1.value      <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			acc_q        <= '0;
			dec_q        <= 1'b1;
			sl_q         <= 1'b0;
			dl_q         <= 1'b0;
			u_q          <= 1'b0;
			bad_q        <= 1'b0;
			rec_valid_s1 <= 1'b0;
		end else begin
			if (take && cls.is_final)
				rec_valid_s1 <= 1'b1;
			else if (rec_ready)
				rec_valid_s1 <= 1'b0;
			if (take) begin
				if (cls.is_final) begin
					phase_q <= PH_START;
					acc_q   <= '0;
					dec_q   <= 1'b1;
					sl_q    <= 1'b0;
					dl_q    <= 1'b0;
					u_q     <= 1'b0;
					bad_q   <= 1'b0;
				end else begin
					phase_q <= phase_d;
					acc_q   <= acc_d;
					dec_q   <= dec_d;
					sl_q    <= sl_d;
					dl_q    <= dl_d;
					u_q     <= u_d;
					bad_q   <= bad_d;
				end
			end
		end
	end

endmodule

// File: sv/ilp_typer.sv
// Type selection against the configured maxima, plus the output register.
// Holds the six limit registers. Depends on ilp_pkg and ilp_out_if.
module ilp_typer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [ilp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ilp_pkg::VALUE_W-1:0]   cfg_data,
	input  logic                          rec_valid,
	output logic                          rec_ready,
	input  ilp_pkg::lit_rec_t             rec,
	ilp_out_if.source                     lit_out
);
	import ilp_pkg::*;

	logic [VALUE_W-1:0]  max_q [NUM_TYPES];
	logic                out_valid_q;
	logic [VALUE_W-1:0]  value_q;
	logic [TYPE_W-1:0]   type_q;
	logic [STATUS_W-1:0] status_q;
	logic [NUM_TYPES-1:0] fit;
	logic [TYPE_W-1:0]   first;
	logic [TYPE_W-1:0]   pick;
	logic                found;
	logic                allow_u;
	logic                allow_s;

	assign allow_u = !rec.is_decimal || rec.seen_u;
	assign allow_s = !rec.seen_u;
	assign first   = rec.double_l ? TY_LLONG : (rec.single_l ? TY_LONG : TY_INT);

	always_comb begin
		for (int i = 0; i < NUM_TYPES; i++) begin
			fit[i] = (TYPE_W'(i) >= first) && (i[0] ? allow_u : allow_s)
				&& (rec.value <= max_q[i]);
		end
	end

	always_comb begin
		found = 1'b0;
		pick  = TY_INT;
		for (int i = NUM_TYPES - 1; i >= 0; i--) begin
			if (fit[i]) begin
				found = 1'b1;
				pick  = TYPE_W'(i);
			end
		end
	end

	assign rec_ready             = !out_valid_q || lit_out.ready;
	assign lit_out.valid         = out_valid_q;
	assign lit_out.literal_value = value_q;
	assign lit_out.type_code     = type_q;
	assign lit_out.status        = status_q;

	always_ff @(posedge clk) begin
		if (rec_valid && rec_ready) begin
			if (rec.bad) begin
				value_q  <= '0;
				type_q   <= TY_INT;
				status_q <= ST_INVALID;
			end else begin
				value_q  <= rec.value;
				type_q   <= found ? pick : TY_INT;
				status_q <= found ? ST_OK : ST_OVERFLOW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_TYPES; i++)
				max_q[i] <= RST_MAX[i];
		end else begin
			if (rec_valid && rec_ready)
				out_valid_q <= 1'b1;
			else if (lit_out.ready)
				out_valid_q <= 1'b0;
			if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_TYPES)))
				max_q[cfg_index] <= cfg_data;
		end
	end

endmodule

// File: sv/integer_literal_parser.sv
// Integer literal parser, top level.
// Characters of one C integer literal arrive on char_in, one per beat, with
// is_final set on the last one. For each final character one result beat
// leaves on lit_out: the value mod 2^64 (0 if invalid), chosen type, status.
// Six 64-bit type limits are written through cfg_wr_en/cfg_index/cfg_data
// (index 0..5: int, uint, long, ulong, llong, ullong); other indexes are
// dropped. Write them only while no literal is in flight.
// Throughput: one character per cycle while lit_out takes results, set by the
// combinational accumulator update (shift-and-add for base 8, 10, 16).
// A final character is written into the queue, then into the record register
// with the state update, then compared against the limits into the output
// register that drives lit_out.
// A two-entry queue separates the classifier from the state update and the
// record and output registers carry the result, so input keeps flowing while
// a result waits; when lit_out stalls the pipeline fills and char_in.ready
// drops once the queue is full.
// Reset (arst_n low) empties the pipeline, clears the literal state and
// restores the limits to the native C sizes of a 64-bit target.
// Depends on ilp_pkg, ilp_if, ilp_front, ilp_back, ilp_typer.
module integer_literal_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	ilp_in_if.sink                        char_in,
	ilp_out_if.source                     lit_out,
	input  logic                          cfg_wr_en,
	input  logic [ilp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ilp_pkg::VALUE_W-1:0]   cfg_data
);
	import ilp_pkg::*;

	logic        cls_valid;
	logic        cls_ready;
	char_class_t cls;
	logic        rec_valid;
	logic        rec_ready;
	lit_rec_t    rec;

	ilp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_in),
		.cls_valid (cls_valid),
		.cls_ready (cls_ready),
		.cls       (cls)
	);

	ilp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (cls_valid),
		.cls_ready (cls_ready),
		.cls       (cls),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec)
	);

	ilp_typer u_typer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec),
		.lit_out   (lit_out)
	);

endmodule

// File: verif/tb_integer_literal_parser.sv
`timescale 1ns / 100ps
// Testbench for integer_literal_parser: directed literals, then random literals
// under changing type limits and handshake idling, checked against a predictor.
// Depends on ilp_pkg, ilp_if and the parser RTL.
module tb_integer_literal_parser;
	import ilp_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_CHARS  = 50;
	localparam int NUM_PHASES   = 8;
	localparam int MAX_REPORTS  = 10;

	typedef enum logic [2:0] {
		LT_INT, LT_UINT, LT_LONG, LT_ULONG, LT_LLONG, LT_ULLONG
	} lit_type_e;

	typedef enum logic [2:0] {
		CFG_INT_MAX, CFG_UINT_MAX, CFG_LONG_MAX, CFG_ULONG_MAX, CFG_LLONG_MAX, CFG_ULLONG_MAX
	} limit_reg_e;

	typedef enum logic [2:0] {
		P_START, P_ZERO, P_OCT, P_HEX, P_DEC, P_SUFFIX
	} parse_state_e;

	typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_e;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [TYPE_W-1:0]   kind;
		logic [STATUS_W-1:0] status;
	} lit_result_t;

	typedef struct {
		string       text;
		int          raw;
		bit          typed;
		lit_result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VALUE_W-1:0] cfg_data;

	ilp_in_if  char_in();
	ilp_out_if lit_out();

	integer_literal_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.char_in(char_in),
		.lit_out(lit_out),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	parse_state_e       parse_state;
	logic [VALUE_W-1:0] acc_value;
	bit                 base_is_dec;
	bit                 one_l;
	bit                 two_l;
	bit                 has_u;
	bit                 broken;
	logic [VALUE_W-1:0] type_limit [NUM_TYPES];

	lit_result_t pending_literals [$];
	logic [7:0]  literal_text [$];

	int src_idle_pct;
	int sink_stall_pct;
	int errors;
	int quiet_cycles;

	stim_row_t directed_rows [11] = '{
		'{"0",    -1,  1, '{64'd0, LT_INT,  ST_OK}},
		'{"0x",   -1,  1, '{64'd0, LT_INT,  ST_OK}},
		'{"u",    -1,  1, '{64'd0, LT_UINT, ST_OK}},
		'{"09",   -1,  1, '{64'd0, LT_INT,  ST_INVALID}},
		'{"1lll", -1,  1, '{64'd0, LT_INT,  ST_INVALID}},
		'{"uU",   -1,  1, '{64'd0, LT_INT,  ST_INVALID}},
		'{"",     0,   1, '{64'd0, LT_INT,  ST_INVALID}},
		'{"",     255, 1, '{64'd0, LT_INT,  ST_INVALID}},
		'{"5g7",  -1,  1, '{64'd0, LT_INT,  ST_INVALID}},
		'{"0XaL", -1,  0, '{64'd0, LT_INT,  ST_OK}},
		'{"017ll",-1,  0, '{64'd0, LT_INT,  ST_OK}}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_literal_state();
		parse_state = P_START;
		acc_value   = '0;
		base_is_dec = 1'b1;
		one_l       = 1'b0;
		two_l       = 1'b0;
		has_u       = 1'b0;
		broken      = 1'b0;
	endfunction

	function automatic void fold_digit(input logic [4:0] radix, input logic [7:0] digit);
		acc_value = acc_value * radix + digit;
	endfunction

	function automatic void take_suffix_letter(input logic [7:0] c);
		parse_state = P_SUFFIX;
		if (c == "l" || c == "L") begin
			if (one_l) begin
				one_l = 1'b0;
				two_l = 1'b1;
			end else if (two_l) begin
				broken = 1'b1;
			end else begin
				one_l = 1'b1;
			end
		end else if (c == "u" || c == "U") begin
			if (has_u)
				broken = 1'b1;
			has_u = 1'b1;
		end else begin
			broken = 1'b1;
		end
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		bit is_dec;
		bit is_oct;
		is_dec = (c >= "0" && c <= "9");
		is_oct = (c >= "0" && c <= "7");
		if (broken)
			return;
		case (parse_state)
			P_START: begin
				if (c == "0") begin
					base_is_dec = 1'b0;
					parse_state = P_ZERO;
				end else if (is_dec) begin
					parse_state = P_DEC;
					fold_digit(5'd10, c - "0");
				end else begin
					take_suffix_letter(c);
				end
			end
			P_ZERO: begin
				if (c == "x" || c == "X") begin
					parse_state = P_HEX;
				end else begin
					parse_state = P_OCT;
					if (is_oct)
						fold_digit(5'd8, c - "0");
					else
						take_suffix_letter(c);
				end
			end
			P_OCT: begin
				if (is_oct)
					fold_digit(5'd8, c - "0");
				else
					take_suffix_letter(c);
			end
			P_HEX: begin
				if (is_dec)
					fold_digit(5'd16, c - "0");
				else if (c >= "a" && c <= "f")
					fold_digit(5'd16, c - "a" + 8'd10);
				else if (c >= "A" && c <= "F")
					fold_digit(5'd16, c - "A" + 8'd10);
				else
					take_suffix_letter(c);
			end
			P_DEC: begin
				if (is_dec)
					fold_digit(5'd10, c - "0");
				else
					take_suffix_letter(c);
			end
			default: take_suffix_letter(c);
		endcase
	endfunction

	function automatic lit_result_t close_literal();
		lit_result_t r;
		int first_kind;
		bit allow_unsigned;
		bit allow_signed;
		r = '{value: '0, kind: LT_INT, status: ST_OK};
		if (broken) begin
			r.status = ST_INVALID;
		end else begin
			first_kind = two_l ? LT_LLONG : (one_l ? LT_LONG : LT_INT);
			allow_unsigned = !base_is_dec || has_u;
			allow_signed = !has_u;
			r.value = acc_value;
			r.status = ST_OVERFLOW;
			for (int k = first_kind; k < NUM_TYPES; k++) begin
				if ((k % 2 == 1 && allow_unsigned) || (k % 2 == 0 && allow_signed)) begin
					if (acc_value <= type_limit[k]) begin
						r.kind = TYPE_W'(k);
						r.status = ST_OK;
						break;
					end
				end
			end
		end
		clear_literal_state();
		return r;
	endfunction

	task automatic send_beat(input logic [7:0] c, input bit last);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			char_in.valid = 1'b0;
			@(negedge clk);
		end
		char_in.valid = 1'b1;
		char_in.char_code = c;
		char_in.is_final = last;
		@(posedge clk);
		while (!char_in.ready)
			@(posedge clk);
		parse_char(c);
		if (last)
			pending_literals.push_back(close_literal());
	endtask

	task automatic send_literal();
		for (int i = 0; i < literal_text.size(); i++)
			send_beat(literal_text[i], i == literal_text.size() - 1);
	endtask

	task automatic drain();
		@(negedge clk);
		char_in.valid = 1'b0;
		while (pending_literals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input limit_reg_e idx, input logic [VALUE_W-1:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		type_limit[idx] = val;
	endtask

	task automatic set_idle(input idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			IDLE_SRC:  begin src_idle_pct = 48; sink_stall_pct = 0;  end
			IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 48; end
			default:   begin src_idle_pct = 23; sink_stall_pct = 23; end
		endcase
	endtask

	function automatic logic [VALUE_W-1:0] random_limit();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return {32'd0, $urandom};
			3: return {$urandom, $urandom};
			default: return VALUE_W'($urandom_range(999));
		endcase
	endfunction

	function automatic logic [7:0] hex_char(input int d);
		return (d < 10) ? 8'("0" + d) : 8'("a" + d - 10);
	endfunction

	task automatic build_literal();
		int nd;
		int nl;
		int nu;
		int upos;
		string body;
		logic [VALUE_W-1:0] v;
		literal_text.delete();
		if ($urandom_range(9) == 0) begin
			// land on a type limit or one off it
			v = type_limit[$urandom_range(NUM_TYPES - 1)] + VALUE_W'($urandom_range(2))
				- VALUE_W'(1);
			case ($urandom_range(2))
				0: body = $sformatf("%0d", v);
				1: body = $sformatf("0%0o", v);
				default: body = $sformatf("0x%0h", v);
			endcase
			for (int i = 0; i < body.len(); i++)
				literal_text.push_back(body[i]);
		end else begin
			nd = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(6, 1);
			case ($urandom_range(2))
				0: begin
					literal_text.push_back(8'("1" + $urandom_range(8)));
					repeat (nd - 1) literal_text.push_back(8'("0" + $urandom_range(9)));
				end
				1: begin
					literal_text.push_back("0");
					repeat (nd - 1) literal_text.push_back(8'("0" + $urandom_range(7)));
				end
				default: begin
					literal_text.push_back("0");
					literal_text.push_back("x");
					if ($urandom_range(19) == 0)
						nd = 0;
					repeat (nd) literal_text.push_back(hex_char($urandom_range(15)));
				end
			endcase
		end
		foreach (literal_text[i])
			if (((literal_text[i] >= "a" && literal_text[i] <= "f") || literal_text[i] == "x")
					&& $urandom_range(1))
				literal_text[i] = literal_text[i] ^ 8'h20;
		nl = $urandom_range(2);
		nu = $urandom_range(1);
		upos = $urandom_range(nl);
		for (int i = 0; i <= nl; i++) begin
			if (nu != 0 && i == upos)
				literal_text.push_back($urandom_range(1) ? "u" : "U");
			if (i < nl)
				literal_text.push_back($urandom_range(1) ? "l" : "L");
		end
		if ($urandom_range(99) < 15) begin
			case ($urandom_range(2))
				0: literal_text.insert($urandom_range(literal_text.size()), 8'($urandom_range(255)));
				1: literal_text.push_back($urandom_range(1) ? ($urandom_range(1) ? "l" : "L")
					: ($urandom_range(1) ? "u" : "U"));
				default: begin
					literal_text.delete();
					repeat ($urandom_range(4, 1)) literal_text.push_back(8'($urandom_range(255)));
				end
			endcase
		end
	endtask

	always @(negedge clk)
		lit_out.ready = ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		lit_result_t want;
		if (arst_n && lit_out.valid && lit_out.ready) begin
			if (pending_literals.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result beat: value %0h type %0d status %0d",
						lit_out.literal_value, lit_out.type_code, lit_out.status);
			end else begin
				want = pending_literals.pop_front();
				if (lit_out.literal_value !== want.value) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("literal_value mismatch: expected %0h, got %0h",
							want.value, lit_out.literal_value);
				end
				if (lit_out.type_code !== want.kind) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("type_code mismatch: expected %0d, got %0d",
							want.kind, lit_out.type_code);
				end
				if (lit_out.status !== want.status) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("status mismatch: expected %0d, got %0d",
							want.status, lit_out.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (char_in.valid && char_in.ready) || (lit_out.valid && lit_out.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		char_in.valid = 1'b0;
		char_in.char_code = '0;
		char_in.is_final = 1'b0;
		errors = 0;
		quiet_cycles = 0;
		type_limit[CFG_INT_MAX]    = 64'd2147483647;
		type_limit[CFG_UINT_MAX]   = 64'd4294967295;
		type_limit[CFG_LONG_MAX]   = 64'd9223372036854775807;
		type_limit[CFG_ULONG_MAX]  = '1;
		type_limit[CFG_LLONG_MAX]  = 64'd9223372036854775807;
		type_limit[CFG_ULLONG_MAX] = '1;
		clear_literal_state();
		set_idle(IDLE_NONE);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r]) begin
			literal_text.delete();
			if (directed_rows[r].text.len() == 0) begin
				literal_text.push_back(8'(directed_rows[r].raw));
			end else begin
				for (int i = 0; i < directed_rows[r].text.len(); i++)
					literal_text.push_back(directed_rows[r].text[i]);
			end
			send_literal();
			if (directed_rows[r].typed)
				pending_literals[$] = directed_rows[r].want;
		end
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			int sent;
			case (ph)
				0: ;
				1: for (int k = 0; k < NUM_TYPES; k++) write_limit(limit_reg_e'(k), '0);
				2: for (int k = 0; k < NUM_TYPES; k++) write_limit(limit_reg_e'(k), '1);
				3: begin
					// 16-bit int target
					write_limit(CFG_INT_MAX, 64'd32767);
					write_limit(CFG_UINT_MAX, 64'd65535);
					write_limit(CFG_LONG_MAX, 64'd2147483647);
					write_limit(CFG_ULONG_MAX, 64'd4294967295);
					write_limit(CFG_LLONG_MAX, 64'd9223372036854775807);
					write_limit(CFG_ULLONG_MAX, '1);
				end
				default: for (int k = 0; k < NUM_TYPES; k++) write_limit(limit_reg_e'(k), random_limit());
			endcase
			set_idle(idle_mode_e'(ph % 4));
			sent = 0;
			while (sent < PHASE_CHARS) begin
				build_literal();
				send_literal();
				sent += literal_text.size();
			end
			drain();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
